>>> hdl/rklt_pkg.sv
// Shared types, constants and helpers for the reentrant key lock table.
// No dependencies; imported by rklt_slot_store and reentrant_key_lock_table_core.
`timescale 1ns / 1ps

package rklt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_BITS      = 64;
  localparam int DEPTH_BITS    = 16;

  localparam int SLOT_AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int INDEX_W   = 32;
  localparam int OWNER_W   = 64;
  localparam int KEY_IN_W  = 64;
  localparam int STATUS_W  = 3;
  localparam int HOLD_W    = 16;

  // Stream payload layout
  localparam int IN_RAW_W  = 1 + INDEX_W + KEY_IN_W + OWNER_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = STATUS_W + HOLD_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int OP_LSB    = 0;
  localparam int INDEX_LSB = 1;
  localparam int KEY_LSB   = INDEX_LSB + INDEX_W;
  localparam int OWNER_LSB = KEY_LSB + KEY_IN_W;

  localparam int DEPTH_EXT_W = (DEPTH_BITS > HOLD_W) ? DEPTH_BITS : HOLD_W;

  localparam logic [SLOT_AW-1:0]    LAST_SLOT = SLOT_AW'(TABLE_ENTRIES - 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_NO_OWNER  = 3'd1,
    ST_HELD      = 3'd2,
    ST_FULL      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_IGNORED   = 3'd5,
    ST_SATURATED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE
  } fsm_t;

  typedef struct packed {
    logic [INDEX_W-1:0]    index;
    logic [KEY_BITS-1:0]   key;
    logic [OWNER_W-1:0]    owner;
    logic [DEPTH_BITS-1:0] depth;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    logic               valid;
    entry_t             data;
  } slot_wr_t;

  // Clamp a depth to the width of the reported hold depth
  function automatic logic [HOLD_W-1:0] depth_out(input logic [DEPTH_BITS-1:0] d);
    logic [DEPTH_EXT_W-1:0] e;
    e = DEPTH_EXT_W'(d);
    if (e > DEPTH_EXT_W'({HOLD_W{1'b1}})) begin
      return {HOLD_W{1'b1}};
    end
    return e[HOLD_W-1:0];
  endfunction

endpackage

>>> hdl/rklt_slot_store.sv
// Slot memory of the lock table: entry RAM with a registered read port,
// plus per-slot valid flops cleared at reset. Depends on rklt_pkg.
`timescale 1ns / 1ps

module rklt_slot_store (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [rklt_pkg::SLOT_AW-1:0] rd_addr,
  output rklt_pkg::entry_t       rd_data,
  output logic                   rd_valid,
  input  rklt_pkg::slot_wr_t     wr
);
  import rklt_pkg::*;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr.we) begin
        valid[wr.addr] <= wr.valid;
      end
    end
  end

endmodule

>>> hdl/reentrant_key_lock_table_core.sv
// Reentrant lock table: one request in, one status out, state in rklt_slot_store.
// Depends on rklt_pkg and rklt_slot_store.
// An item is accepted in the idle state; the slots are then read in turn through
// the single read port of the slot memory, stopping at the first key match or the
// last slot, and the decide state decides and writes the entry back. Items are
// handled one at a time; the next one is taken while the previous result still
// waits in the output register. Valid bits sit in flops, so no clearing pass runs
// after reset. Keys compare on (index_number, low KEY_BITS of key_value).
`timescale 1ns / 1ps

module reentrant_key_lock_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation[0], index_number[32:1], key_value[96:33], owner_id[160:97], zero fill
  input  logic [rklt_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[2:0], hold_depth[18:3], zero fill
  output logic [rklt_pkg::OUT_W-1:0]  m_tdata
);
  import rklt_pkg::*;

  fsm_t                  state, state_next;

  op_t                   req_op;
  logic [INDEX_W-1:0]    req_index;
  logic [KEY_BITS-1:0]   req_key;
  logic [OWNER_W-1:0]    req_owner;

  logic [SLOT_AW-1:0]    scan_addr;
  logic                  hit;
  logic [SLOT_AW-1:0]    hit_slot;
  logic [OWNER_W-1:0]    hit_owner;
  logic [DEPTH_BITS-1:0] hit_depth;
  logic                  free_found;
  logic [SLOT_AW-1:0]    free_slot;

  status_t               status_q, status_next;
  logic [HOLD_W-1:0]     depth_q, depth_next;

  logic [SLOT_AW-1:0]    rd_addr;
  entry_t                rd_data;
  logic                  rd_valid;
  slot_wr_t              wr;

  logic                  accept;
  logic                  slot_match;
  logic                  out_free;
  logic                  load_out;
  logic [DEPTH_BITS-1:0] dep_dec;

  rklt_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr       (wr)
  );

  assign s_tready   = (state == FSM_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign slot_match = rd_valid && (rd_data.index == req_index) && (rd_data.key == req_key);
  assign dep_dec    = hit_depth - DEPTH_BITS'(1);
  assign m_tdata    = {(OUT_W - OUT_RAW_W)'(0), depth_q, status_q};

  always_comb begin
    state_next  = state;
    rd_addr     = '0;
    load_out    = 1'b0;
    status_next = ST_IGNORED;
    depth_next  = '0;
    wr          = '0;
    wr.data     = '{index: req_index, key: req_key, owner: req_owner, depth: '0};
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        rd_addr = scan_addr + SLOT_AW'(1);
        if (slot_match || scan_addr == LAST_SLOT) begin
          state_next = FSM_DECIDE;
        end
      end
      FSM_DECIDE: begin
        if (req_op == OP_ACQUIRE) begin
          if (req_owner == '0) begin
            status_next = ST_NO_OWNER;
          end else if (hit) begin
            if (hit_owner != req_owner) begin
              status_next = ST_HELD;
              depth_next  = depth_out(hit_depth);
            end else if (hit_depth == DEPTH_MAX) begin
              status_next = ST_SATURATED;
              depth_next  = depth_out(DEPTH_MAX);
            end else begin
              status_next   = ST_GRANTED;
              wr.we         = 1'b1;
              wr.addr       = hit_slot;
              wr.valid      = 1'b1;
              wr.data.depth = hit_depth + DEPTH_BITS'(1);
              depth_next    = depth_out(wr.data.depth);
            end
          end else if (free_found) begin
            status_next   = ST_GRANTED;
            wr.we         = 1'b1;
            wr.addr       = free_slot;
            wr.valid      = 1'b1;
            wr.data.depth = DEPTH_BITS'(1);
            depth_next    = HOLD_W'(1);
          end else begin
            status_next = ST_FULL;
          end
        end else begin
          if (!hit) begin
            status_next = ST_IGNORED;
          end else if (hit_owner != req_owner || hit_depth == '0) begin
            status_next = ST_IGNORED;
            depth_next  = depth_out(hit_depth);
          end else begin
            status_next   = ST_RELEASED;
            wr.we         = 1'b1;
            wr.addr       = hit_slot;
            wr.valid      = (dep_dec != '0);
            wr.data.depth = dep_dec;
            depth_next    = depth_out(dep_dec);
          end
        end
        // Hold the decision and the write back until the output register frees up
        if (out_free) begin
          load_out   = 1'b1;
          state_next = FSM_IDLE;
        end else begin
          wr.we = 1'b0;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      m_tvalid   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (state == FSM_SCAN) begin
        if (slot_match) begin
          hit <= 1'b1;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= op_t'(s_tdata[OP_LSB]);
      req_index <= s_tdata[INDEX_LSB +: INDEX_W];
      req_key   <= s_tdata[KEY_LSB +: KEY_BITS];
      req_owner <= s_tdata[OWNER_LSB +: OWNER_W];
      scan_addr <= '0;
    end else if (state == FSM_SCAN) begin
      scan_addr <= scan_addr + SLOT_AW'(1);
      if (slot_match) begin
        hit_slot  <= scan_addr;
        hit_owner <= rd_data.owner;
        hit_depth <= rd_data.depth;
      end
      if (!rd_valid && !free_found) begin
        free_slot <= scan_addr;
      end
    end
    if (load_out) begin
      status_q <= status_next;
      depth_q  <= depth_next;
    end
  end

  // One request in flight: no second transfer right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while a request is in flight");

  // The slot memory is only written when a decision is made
  a_write_in_decide: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state == FSM_DECIDE && load_out))
    else $error("slot write outside the decision cycle");

  // Freeing a slot only happens when its depth runs out
  a_free_at_zero: assert property (@(posedge clk) disable iff (rst)
    (wr.we && !wr.valid) |-> (wr.data.depth == '0 && status_next == ST_RELEASED))
    else $error("slot freed with a nonzero depth");

  // A grant or a saturated reacquire always reports a held depth
  a_grant_depth: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == ST_GRANTED || m_tdata[2:0] == ST_SATURATED))
      |-> (m_tdata[18:3] != '0))
    else $error("grant reported with zero depth");

endmodule
